// File: sv/bara_pkg.sv
// Shared widths, constants, types and table functions of the barometric altitude core.
package bara_pkg;

   localparam int PRESS_W     = 17;
   localparam int TIME_W      = 32;
   localparam int INTERVAL_W  = 16;
   localparam int ALT_W       = 24;
   localparam int RATE_W      = 21;
   localparam int RATE_MAG_W  = 20;
   localparam int KNOT_P_W    = 18;
   localparam int SEG_OFF_W   = 14;
   localparam int AMAG_W      = 24;
   localparam int SCALE_W     = 10;
   localparam int RPROD_W     = 34;
   localparam int DIV_NUM_W   = 37;
   localparam int DIV_DEN_W   = 32;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   localparam logic [INTERVAL_W-1:0]   INTERVAL_RESET = 16'd1000;
   localparam logic signed [ALT_W-1:0] ALT_MAX        = 24'sd6000000;
   localparam logic signed [ALT_W-1:0] ALT_MIN        = -24'sd100000;
   localparam logic [RATE_MAG_W-1:0]   RATE_LIMIT     = 20'd1000000;
   localparam logic [SCALE_W-1:0]      RATE_SCALE     = 10'd1000;

   localparam logic [63:0] PRESSURE_SPAN    = 64'd131072;
   localparam logic [63:0] LAYER_LIMIT_PA   = 64'd22632;
   localparam logic [63:0] LOWER_OFFSET_Q32 = 64'd72879122497;
   localparam logic [63:0] LOWER_SCALE_Q16  = 64'd28808002011;
   localparam logic [63:0] UPPER_REF_Q32    = 64'd71419424604;
   localparam logic [63:0] UPPER_EXP_Q32    = 64'd817186248;
   localparam logic [63:0] UPPER_SCALE_CM   = 64'd4433070;
   localparam logic [63:0] ONE_Q31          = 64'h0000_0000_8000_0000;
   localparam logic [63:0] HALF_Q31         = 64'h0000_0000_4000_0000;
   localparam logic [63:0] ONE_Q32          = 64'h0000_0001_0000_0000;
   localparam logic [63:0] MASK_32          = 64'h0000_0000_FFFF_FFFF;
   localparam int          POW_BITS         = 24;

   typedef struct packed {
      logic [KNOT_P_W-1:0]     pressure;
      logic signed [ALT_W-1:0] altitude;
   } knot_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = 64'd0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bitv > rem) begin
            bitv = bitv >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] log2_q32(input logic [63:0] p);
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] n;
      n = 64'd0;
      for (int i = 0; i < 63; i++) begin
         if ((p >> (n + 64'd1)) != 64'd0) begin
            n = n + 64'd1;
         end
      end
      x    = p << (64'd30 - n);
      frac = 64'd0;
      for (int i = 0; i < 32; i++) begin
         x    = (x * x) >> 30;
         frac = frac << 1;
         if (x >= ONE_Q31) begin
            x    = x >> 1;
            frac = frac | 64'd1;
         end
      end
      return (n << 32) + frac;
   endfunction

   function automatic logic [63:0] pow2_q31(input logic [63:0] f);
      logic [63:0] acc;
      logic [63:0] root;
      acc  = ONE_Q31;
      root = ONE_Q32;
      for (int i = 1; i <= POW_BITS; i++) begin
         root = isqrt64(root << 31);
         if (f[32-i]) begin
            acc = (acc * root + HALF_Q31) >> 31;
         end
      end
      return acc;
   endfunction

   function automatic logic signed [63:0] law_cm(input logic [63:0] p);
      logic [63:0] l;
      logic [63:0] d;
      logic [63:0] e;
      logic [63:0] g;
      if (p == 64'd0) begin
         return 64'(ALT_MAX);
      end
      l = log2_q32(p);
      if (p <= LAYER_LIMIT_PA) begin
         d = (LOWER_OFFSET_Q32 - l) >> 16;
         return $signed((LOWER_SCALE_Q16 * d + ONE_Q31) >> 32);
      end
      if (l >= UPPER_REF_Q32) begin
         e = ((l - UPPER_REF_Q32) * UPPER_EXP_Q32 + ONE_Q31) >> 32;
         g = pow2_q31(e & MASK_32);
      end else begin
         e = ((UPPER_REF_Q32 - l) * UPPER_EXP_Q32 + ONE_Q31) >> 32;
         g = (e == 64'd0) ? ONE_Q31 : (pow2_q31((ONE_Q32 - e) & MASK_32) >> 1);
      end
      if (g <= ONE_Q31) begin
         return $signed((UPPER_SCALE_CM * (ONE_Q31 - g) + HALF_Q31) >> 31);
      end
      return -$signed((UPPER_SCALE_CM * (g - ONE_Q31) + HALF_Q31) >> 31);
   endfunction

   function automatic logic signed [63:0] clamp_alt(input logic signed [63:0] v);
      logic signed [63:0] lo;
      logic signed [63:0] hi;
      lo = 64'(ALT_MIN);
      hi = 64'(ALT_MAX);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

// File: sv/barometric_altitude_ascent_rate_core.sv
// Top level: pressure to altitude by table interpolation, and ascent rate over time.
//
// Each transfer on the req_ channel carries one pressure sample in pascals and a
// millisecond timestamp. Each accepted sample gives exactly one transfer on the rsp_
// channel with the altitude in centimeters, the ascent rate in cm/s and a flag in
// rsp_tuser that marks a recomputed rate. The csr_ port sets the minimum interval
// between rate updates; it is to be written only while no sample is in flight,
// which the block itself does not enforce. One sample is processed at a time.
// Each sample takes two lookups in the knot table and one pass of the 37-step
// bit-serial divider for the interpolation, and a second pass for the rate when
// it is recomputed. Once the output register is free, the result is loaded into it
// and the block returns to idle to accept the next sample. The output register frees
// the input side: while a result waits for rsp_tready, the next sample is accepted
// and computed, and then held until the output register is free. Reset sets the
// interval to 1000 ms, clears the kept altitude and update time to zero and drops
// any pending result.
module barometric_altitude_ascent_rate_core #(
   parameter int CURVE_SEGMENTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pressure_pa [16:0], time_ms [48:17], zero fill [55:49]
   input  logic [bara_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // altitude_cm [23:0], ascent_rate_cm_s [44:24], zero fill [47:45]
   output logic [bara_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rate_updated [0]
   output logic                               rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [bara_pkg::INTERVAL_W-1:0]    csr_wr_data
);

   localparam int IDX_W   = $clog2(CURVE_SEGMENTS + 1);
   localparam int KPROD_W = bara_pkg::PRESS_W + IDX_W;
   localparam int IPROD_W = bara_pkg::AMAG_W + bara_pkg::SEG_OFF_W;
   localparam int ALT_W   = bara_pkg::ALT_W;
   localparam int RATE_W  = bara_pkg::RATE_W;
   localparam int NUM_W   = bara_pkg::DIV_NUM_W;
   localparam int DEN_W   = bara_pkg::DIV_DEN_W;
   localparam int OFF_W   = bara_pkg::SEG_OFF_W;
   localparam int AMAG_W  = bara_pkg::AMAG_W;
   localparam int PAD_W   = bara_pkg::RSP_TDATA_W - ALT_W - RATE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK0,
      S_LOOK1,
      S_LOOK2,
      S_PROD,
      S_DIV_A,
      S_RATE,
      S_RATE_MUL,
      S_DIV_R,
      S_OUT
   } state_type;

   state_type                         state_ff, state_in;
   logic [bara_pkg::PRESS_W-1:0]      pressure_ff, pressure_in;
   logic [bara_pkg::TIME_W-1:0]       time_ff, time_in;
   logic [IDX_W-1:0]                  seg_ff, seg_in;
   logic [bara_pkg::TIME_W-1:0]       dt_ff, dt_in;
   logic                              upd_ff, upd_in;
   logic signed [ALT_W-1:0]           a0_ff, a0_in;
   logic [bara_pkg::KNOT_P_W-1:0]     knot_p_ff, knot_p_in;
   logic [OFF_W-1:0]                  seg_len_ff, seg_len_in;
   logic [OFF_W-1:0]                  seg_off_ff, seg_off_in;
   logic [AMAG_W-1:0]                 amag_ff, amag_in;
   logic                              aneg_ff, aneg_in;
   logic signed [ALT_W-1:0]           alt_ff, alt_in;
   logic [AMAG_W-1:0]                 rmag_ff, rmag_in;
   logic                              rneg_ff, rneg_in;
   logic signed [RATE_W-1:0]          rate_ff, rate_in;
   logic signed [ALT_W-1:0]           prev_alt_ff, prev_alt_in;
   logic [bara_pkg::TIME_W-1:0]       prev_time_ff, prev_time_in;
   logic [bara_pkg::INTERVAL_W-1:0]   interval_ff, interval_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ALT_W-1:0]           rsp_alt_ff, rsp_alt_in;
   logic signed [RATE_W-1:0]          rsp_rate_ff, rsp_rate_in;
   logic                              rsp_upd_ff, rsp_upd_in;

   logic [IDX_W-1:0]                  rom_addr;
   bara_pkg::knot_type                rom_data;
   logic                              div_start;
   logic [NUM_W-1:0]                  div_num;
   logic [DEN_W-1:0]                  div_den;
   logic                              div_busy;
   logic                              div_done;
   logic [NUM_W-1:0]                  div_quot;

   logic [bara_pkg::PRESS_W-1:0]      req_pressure_w;
   logic [bara_pkg::TIME_W-1:0]       req_time_w;
   logic [bara_pkg::TIME_W-1:0]       req_dt_w;
   logic [KPROD_W-1:0]                seg_prod_w;
   logic signed [ALT_W:0]             adiff_w;
   logic [IPROD_W-1:0]                interp_prod_w;
   logic signed [ALT_W:0]             interp_sum_w;
   logic signed [ALT_W:0]             rdiff_w;
   logic [bara_pkg::RPROD_W-1:0]      rate_prod_w;
   logic [bara_pkg::RATE_MAG_W-1:0]   rate_mag_w;
   logic                              out_free_w;

   assign req_pressure_w = req_tdata[bara_pkg::PRESS_W-1:0];
   assign req_time_w     = req_tdata[bara_pkg::PRESS_W+bara_pkg::TIME_W-1:bara_pkg::PRESS_W];
   assign req_dt_w       = req_time_w - prev_time_ff;
   assign seg_prod_w     = req_pressure_w * IDX_W'(CURVE_SEGMENTS);
   assign adiff_w        = {rom_data.altitude[ALT_W-1], rom_data.altitude} - {a0_ff[ALT_W-1], a0_ff};
   assign interp_prod_w  = amag_ff * seg_off_ff;
   assign interp_sum_w   = aneg_ff ? ({a0_ff[ALT_W-1], a0_ff} - $signed({1'b0, div_quot[ALT_W-1:0]}))
                                   : ({a0_ff[ALT_W-1], a0_ff} + $signed({1'b0, div_quot[ALT_W-1:0]}));
   assign rdiff_w        = {alt_ff[ALT_W-1], alt_ff} - {prev_alt_ff[ALT_W-1], prev_alt_ff};
   assign rate_prod_w    = rmag_ff * bara_pkg::RATE_SCALE;
   assign rate_mag_w     = (div_quot > NUM_W'(bara_pkg::RATE_LIMIT)) ? bara_pkg::RATE_LIMIT
                                                                    : div_quot[bara_pkg::RATE_MAG_W-1:0];
   assign out_free_w     = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rom_addr   = (state_ff == S_LOOK0) ? seg_ff : seg_ff + IDX_W'(1);

   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_W'(interp_prod_w) + NUM_W'(seg_len_ff >> 1);
      div_den   = DEN_W'(seg_len_ff);
      if (state_ff == S_RATE_MUL) begin
         div_num = NUM_W'(rate_prod_w) + NUM_W'(dt_ff >> 1);
         div_den = dt_ff;
      end
      if (state_ff == S_PROD || state_ff == S_RATE_MUL) begin
         div_start = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pressure_in  = pressure_ff;
      time_in      = time_ff;
      seg_in       = seg_ff;
      dt_in        = dt_ff;
      upd_in       = upd_ff;
      a0_in        = a0_ff;
      knot_p_in    = knot_p_ff;
      seg_len_in   = seg_len_ff;
      seg_off_in   = seg_off_ff;
      amag_in      = amag_ff;
      aneg_in      = aneg_ff;
      alt_in       = alt_ff;
      rmag_in      = rmag_ff;
      rneg_in      = rneg_ff;
      rate_in      = rate_ff;
      prev_alt_in  = prev_alt_ff;
      prev_time_in = prev_time_ff;
      interval_in  = csr_wr_en ? csr_wr_data : interval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_alt_in   = rsp_alt_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_upd_in   = rsp_upd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pressure_in = req_pressure_w;
               time_in     = req_time_w;
               seg_in      = seg_prod_w[KPROD_W-1:bara_pkg::PRESS_W];
               dt_in       = req_dt_w;
               upd_in      = req_dt_w > bara_pkg::TIME_W'(interval_ff);
               state_in    = S_LOOK0;
            end
         end
         S_LOOK0: begin
            state_in = S_LOOK1;
         end
         S_LOOK1: begin
            a0_in     = rom_data.altitude;
            knot_p_in = rom_data.pressure;
            state_in  = S_LOOK2;
         end
         S_LOOK2: begin
            seg_len_in = OFF_W'(rom_data.pressure - knot_p_ff);
            seg_off_in = OFF_W'({1'b0, pressure_ff} - knot_p_ff);
            aneg_in    = adiff_w[ALT_W];
            amag_in    = adiff_w[ALT_W] ? AMAG_W'(-adiff_w) : AMAG_W'(adiff_w);
            state_in   = S_PROD;
         end
         S_PROD: begin
            state_in = S_DIV_A;
         end
         S_DIV_A: begin
            if (div_done) begin
               if (interp_sum_w > $signed({bara_pkg::ALT_MAX[ALT_W-1], bara_pkg::ALT_MAX})) begin
                  alt_in = bara_pkg::ALT_MAX;
               end else if (interp_sum_w <
                            $signed({bara_pkg::ALT_MIN[ALT_W-1], bara_pkg::ALT_MIN})) begin
                  alt_in = bara_pkg::ALT_MIN;
               end else begin
                  alt_in = interp_sum_w[ALT_W-1:0];
               end
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            rneg_in = rdiff_w[ALT_W];
            rmag_in = rdiff_w[ALT_W] ? AMAG_W'(-rdiff_w) : AMAG_W'(rdiff_w);
            rate_in = '0;
            if (upd_ff) begin
               state_in = S_RATE_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RATE_MUL: begin
            state_in = S_DIV_R;
         end
         S_DIV_R: begin
            if (div_done) begin
               rate_in      = rneg_ff ? RATE_W'(-{1'b0, rate_mag_w}) : RATE_W'({1'b0, rate_mag_w});
               prev_alt_in  = alt_ff;
               prev_time_in = time_ff;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free_w) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in   = alt_ff;
               rsp_rate_in  = rate_ff;
               rsp_upd_in   = upd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pressure_ff <= pressure_in;
      time_ff     <= time_in;
      seg_ff      <= seg_in;
      dt_ff       <= dt_in;
      upd_ff      <= upd_in;
      a0_ff       <= a0_in;
      knot_p_ff   <= knot_p_in;
      seg_len_ff  <= seg_len_in;
      seg_off_ff  <= seg_off_in;
      amag_ff     <= amag_in;
      aneg_ff     <= aneg_in;
      alt_ff      <= alt_in;
      rmag_ff     <= rmag_in;
      rneg_ff     <= rneg_in;
      rate_ff     <= rate_in;
      rsp_alt_ff  <= rsp_alt_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_upd_ff  <= rsp_upd_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_alt_ff  <= '0;
         prev_time_ff <= '0;
         interval_ff  <= bara_pkg::INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_alt_ff  <= prev_alt_in;
         prev_time_ff <= prev_time_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bara_knot_rom #(
      .CURVE_SEGMENTS(CURVE_SEGMENTS)
   ) u_knot_rom (
      .clock  (clock),
      .rd_addr(rom_addr),
      .rd_data(rom_data)
   );

   bara_serial_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_serial_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .busy (div_busy),
      .done (div_done),
      .quot (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_rate_ff, rsp_alt_ff};
   assign rsp_tuser  = rsp_upd_ff;

   a_rate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_upd_ff) |-> (rsp_rate_ff == '0))
      else $error("nonzero rate on a result without update");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !div_busy))
      else $error("sample accepted without entering the lookup");

   a_keep_on_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(prev_time_ff)) |-> $past(upd_ff && state_ff == S_DIV_R))
      else $error("kept update time changed outside a rate update");

endmodule

// File: sv/bara_knot_rom.sv
// Altitude knot table over pressure with a registered read port.
module bara_knot_rom #(
   parameter int CURVE_SEGMENTS = 64
) (
   input  logic                               clock,
   input  logic [$clog2(CURVE_SEGMENTS+1)-1:0] rd_addr,
   output bara_pkg::knot_type                 rd_data
);

   function automatic logic [63:0] knot_pressure(input logic [63:0] k);
      return (k * bara_pkg::PRESSURE_SPAN + 64'(CURVE_SEGMENTS - 1)) / CURVE_SEGMENTS;
   endfunction

   bara_pkg::knot_type knot_rom_w [0:CURVE_SEGMENTS];
   bara_pkg::knot_type rd_data_ff;

   for (genvar g = 0; g <= CURVE_SEGMENTS; g++) begin : g_knot
      localparam logic [63:0]        KNOT_P   = knot_pressure(64'(g));
      localparam logic signed [63:0] KNOT_ALT = bara_pkg::clamp_alt(bara_pkg::law_cm(KNOT_P));
      assign knot_rom_w[g].pressure = bara_pkg::KNOT_P_W'(KNOT_P);
      assign knot_rom_w[g].altitude = bara_pkg::ALT_W'(KNOT_ALT);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= knot_rom_w[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bara_serial_div.sv
// Bit-serial restoring divider that produces one quotient bit per cycle.
module bara_serial_div #(
   parameter int NUM_W = 37,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial_w;
   logic [DEN_W:0]   diff_w;
   logic             fits_w;

   assign trial_w = {rem_ff, quo_ff[NUM_W-1]};
   assign diff_w  = trial_w - {1'b0, den_ff};
   assign fits_w  = trial_w >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits_w ? diff_w[DEN_W-1:0] : trial_w[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits_w};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == '0 && !start) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule
